### rtl/core/tsos_pkg.sv
// -----------------------------------------------------------------------------
// tsos_pkg: shared types and constants of the time switch
// Field widths, register and mode codes, and the structs passed between the
// pipeline stages.
// -----------------------------------------------------------------------------
package tsos_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;
    localparam int DATE_W  = 21;
    localparam int SOD_W   = 17;
    localparam int MASK_W  = 7;
    localparam int MODE_W  = 2;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 21;
    localparam int STAMP_W = DATE_W + SOD_W;

    localparam logic [SOD_W-1:0]  SEC_PER_HOUR = SOD_W'(3600);
    localparam logic [SOD_W-1:0]  SEC_PER_MIN  = SOD_W'(60);
    localparam logic [WDAY_W-1:0] LAST_WEEKDAY = WDAY_W'(6);

    typedef enum logic [MODE_W-1:0] {
        MODE_DATE_CONT = 2'd0,
        MODE_DATE_INT  = 2'd1,
        MODE_WDAY_CONT = 2'd2,
        MODE_WDAY_INT  = 2'd3
    } t_mode;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MODE          = 3'd0,
        CFG_WEEKDAY_MASK  = 3'd1,
        CFG_START_DATE    = 3'd2,
        CFG_START_SECONDS = 3'd3,
        CFG_END_DATE      = 3'd4,
        CFG_END_SECONDS   = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        t_mode              mode;
        logic [MASK_W-1:0]  weekday_mask;
        logic [DATE_W-1:0]  start_date;
        logic [SOD_W-1:0]   start_seconds;
        logic [DATE_W-1:0]  end_date;
        logic [SOD_W-1:0]   end_seconds;
    } t_cfg;

    // after the time-of-day stage
    typedef struct packed {
        logic [DATE_W-1:0] date;
        logic [SOD_W-1:0]  sod;
        logic [WDAY_W-1:0] wday;
    } t_s1;

    // after the compare stage
    typedef struct packed {
        logic ge_start;   // stamp >= start stamp
        logic lt_end;     // stamp <  end stamp
        logic ge_s;       // sod >= start_seconds
        logic lt_e;       // sod <  end_seconds
        logic in_run;     // weekday inside a selected run
        logic prev_on;    // previous weekday selected
        logic is_first;   // weekday opens its run
        logic is_last;    // weekday closes its run
    } t_s2;

endpackage

### rtl/core/tsos_if.sv
// -----------------------------------------------------------------------------
// tsos_if: channel interfaces of the time switch
// Input item, result item and register write channels, valid/ready each.
// -----------------------------------------------------------------------------
interface tsos_in_if import tsos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [YEAR_W-1:0]  now_year;
    logic [MONTH_W-1:0] now_month;
    logic [DAY_W-1:0]   now_day;
    logic [HOUR_W-1:0]  now_hour;
    logic [MIN_W-1:0]   now_minute;
    logic [SEC_W-1:0]   now_second;
    logic [WDAY_W-1:0]  now_weekday;

    modport source (
        output valid, now_year, now_month, now_day, now_hour, now_minute,
               now_second, now_weekday,
        input  ready
    );
    modport sink (
        input  valid, now_year, now_month, now_day, now_hour, now_minute,
               now_second, now_weekday,
        output ready
    );
endinterface

interface tsos_out_if ();
    logic valid;
    logic ready;
    logic output_on;

    modport source (output valid, output_on, input ready);
    modport sink (input valid, output_on, output ready);
endinterface

interface tsos_cfg_if import tsos_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CIDX_W-1:0]  wr_index;
    logic [CDATA_W-1:0] wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink (input valid, wr_index, wr_data, output ready);
endinterface

### rtl/core/tsos_cfg_regs.sv
// -----------------------------------------------------------------------------
// tsos_cfg_regs: configuration register file
// Six registers written by index; unknown indexes are dropped.
// -----------------------------------------------------------------------------
module tsos_cfg_regs import tsos_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsos_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.wr_index))
                CFG_MODE:          n_cfg.mode          = t_mode'(i_cfg.wr_data[MODE_W-1:0]);
                CFG_WEEKDAY_MASK:  n_cfg.weekday_mask  = i_cfg.wr_data[MASK_W-1:0];
                CFG_START_DATE:    n_cfg.start_date    = i_cfg.wr_data[DATE_W-1:0];
                CFG_START_SECONDS: n_cfg.start_seconds = i_cfg.wr_data[SOD_W-1:0];
                CFG_END_DATE:      n_cfg.end_date      = i_cfg.wr_data[DATE_W-1:0];
                CFG_END_SECONDS:   n_cfg.end_seconds   = i_cfg.wr_data[SOD_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### rtl/core/tsos_time_stage.sv
// -----------------------------------------------------------------------------
// tsos_time_stage: first pipeline stage
// Packs the date and turns hour/minute/second into seconds of day.
// -----------------------------------------------------------------------------
module tsos_time_stage import tsos_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tsos_in_if.sink  i_in,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s1      o_s1
);

    logic r_valid;
    t_s1  r_s1;
    t_s1  n_s1;
    logic adv;

    assign adv        = !r_valid || i_ready;
    assign i_in.ready = adv;
    assign o_valid    = r_valid;
    assign o_s1       = r_s1;

    always_comb begin
        n_s1.date = {i_in.now_year, i_in.now_month, i_in.now_day};
        n_s1.sod  = SOD_W'(i_in.now_hour) * SEC_PER_HOUR
                  + SOD_W'(i_in.now_minute) * SEC_PER_MIN
                  + SOD_W'(i_in.now_second);
        n_s1.wday = i_in.now_weekday;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_in.valid) begin
            r_s1 <= n_s1;
        end
    end

endmodule

### rtl/core/tsos_match_stage.sv
// -----------------------------------------------------------------------------
// tsos_match_stage: second pipeline stage
// Date/time stamp compares against the range and weekday run decode.
// -----------------------------------------------------------------------------
module tsos_match_stage import tsos_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_s1      i_s1,
    output logic     o_valid,
    input  logic     i_ready,
    output t_s2      o_s2
);

    logic               r_valid;
    t_s2                r_s2;
    t_s2                n_s2;
    logic               adv;
    logic               full;
    logic               wrap;
    logic [7:0]         run_vec;
    logic [7:0]         first_vec;
    logic [7:0]         last_vec;
    logic [7:0]         sel_vec;
    logic [WDAY_W-1:0]  prev_day;
    logic [STAMP_W-1:0] now_stamp;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_s2    = r_s2;

    // first and last weekday runs join unless every day is selected
    assign full = &i_cfg.weekday_mask;
    assign wrap = i_cfg.weekday_mask[0] && i_cfg.weekday_mask[MASK_W-1] && !full;

    always_comb begin
        sel_vec = {1'b0, i_cfg.weekday_mask};
        // weekday seven only sits in a run that wraps the week
        run_vec = {wrap, i_cfg.weekday_mask};
        first_vec    = '0;
        last_vec     = '0;
        first_vec[0] = i_cfg.weekday_mask[0] && !wrap;
        last_vec[MASK_W-1] = i_cfg.weekday_mask[MASK_W-1] && !wrap;
        for (int d = 1; d < MASK_W; d++) begin
            first_vec[d] = i_cfg.weekday_mask[d] && !i_cfg.weekday_mask[d-1];
        end
        for (int d = 0; d < MASK_W - 1; d++) begin
            last_vec[d] = i_cfg.weekday_mask[d] && !i_cfg.weekday_mask[d+1];
        end
    end

    assign prev_day  = (i_s1.wday == '0) ? LAST_WEEKDAY : i_s1.wday - WDAY_W'(1);
    assign now_stamp = {i_s1.date, i_s1.sod};

    always_comb begin
        n_s2.ge_start = now_stamp >= {i_cfg.start_date, i_cfg.start_seconds};
        n_s2.lt_end   = now_stamp <  {i_cfg.end_date, i_cfg.end_seconds};
        n_s2.ge_s     = i_s1.sod >= i_cfg.start_seconds;
        n_s2.lt_e     = i_s1.sod <  i_cfg.end_seconds;
        n_s2.in_run   = run_vec[i_s1.wday];
        n_s2.prev_on  = sel_vec[prev_day];
        n_s2.is_first = first_vec[i_s1.wday];
        n_s2.is_last  = last_vec[i_s1.wday];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_s2 <= n_s2;
        end
    end

endmodule

### rtl/core/tsos_out_stage.sv
// -----------------------------------------------------------------------------
// tsos_out_stage: last pipeline stage
// Selects the on/off decision by mode and holds the result beat.
// -----------------------------------------------------------------------------
module tsos_out_stage import tsos_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_s2        i_s2,
    tsos_out_if.source o_out
);

    logic r_valid;
    logic r_on;
    logic n_on;
    logic adv;
    logic crosses;
    logic in_window;

    assign adv             = !r_valid || o_out.ready;
    assign o_ready         = adv;
    assign o_out.valid     = r_valid;
    assign o_out.output_on = r_on;

    // daily window runs past midnight
    assign crosses   = i_cfg.start_seconds > i_cfg.end_seconds;
    assign in_window = crosses ? (i_s2.ge_s || i_s2.lt_e) : (i_s2.ge_s && i_s2.lt_e);

    always_comb begin
        unique case (i_cfg.mode)
            MODE_DATE_CONT: n_on = i_s2.ge_start && i_s2.lt_end;
            MODE_DATE_INT:  n_on = i_s2.ge_start && i_s2.lt_end && in_window;
            MODE_WDAY_CONT: n_on = i_s2.in_run
                                && (i_s2.ge_s || !i_s2.is_first)
                                && (i_s2.lt_e || !i_s2.is_last);
            MODE_WDAY_INT:  n_on = crosses
                                ? ((i_s2.ge_s && i_s2.in_run) || (i_s2.lt_e && i_s2.prev_on))
                                : (i_s2.in_run && i_s2.ge_s && i_s2.lt_e);
            default:        n_on = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && i_valid) begin
            r_on <= n_on;
        end
    end

endmodule

### rtl/core/time_switch_output_state.sv
// -----------------------------------------------------------------------------
// time_switch_output_state: programmable time switch
// Gives one on/off bit for each date/time/weekday beat.
// -----------------------------------------------------------------------------
// Takes one input beat per clock while the output is not stalled and returns
// one result beat for each, in order. The path is three register stages:
// seconds-of-day and date packing, then the stamp and weekday compares, then
// the output register. Input ready follows output ready through the stages in
// the same cycle; a stall on the output fills the stages and then holds input
// ready low.
// Registers are written through the configuration channel, which is always
// ready; write them only while no beat is in flight.
module time_switch_output_state import tsos_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsos_in_if.sink    i_in,
    tsos_out_if.source o_out,
    tsos_cfg_if.sink   i_cfg
);

    t_cfg cfg;
    logic s1_valid;
    logic s1_ready;
    t_s1  s1;
    logic s2_valid;
    logic s2_ready;
    t_s2  s2;

    tsos_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    tsos_time_stage u_time (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_s1    (s1)
    );

    tsos_match_stage u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_s1    (s1),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_s2    (s2)
    );

    tsos_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_s2    (s2),
        .o_out   (o_out)
    );

endmodule

### rtl/core/tsos_checker.sv
// -----------------------------------------------------------------------------
// tsos_checker: port-level checks of the time switch
// Watches the channel handshakes and the pipeline latency.
// -----------------------------------------------------------------------------
module tsos_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_on,
    input logic i_cfg_ready
);

    // stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // stalled result beat keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_on))
        else $error("result changed while stalled");

    // a free output side never blocks the input
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready && i_cfg_ready)
        else $error("input or config blocked with output ready");

    // accepted beat comes out after three stages when never stalled
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid)
        else $error("result missing after pipeline latency");

endmodule

bind time_switch_output_state tsos_checker u_tsos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_on    (o_out.output_on),
    .i_cfg_ready (i_cfg.ready)
);
